@@ hdl/dnsaqr_pkg.sv @@
// Shared constants, status codes and byte tables for the DNS A-query responder.
package dnsaqr_pkg;

  localparam int unsigned MAX_PACKET_BYTES_DEF = 256;
  localparam int unsigned MIN_LENGTH           = 17;
  localparam int unsigned HEADER_BYTES         = 12;
  localparam int unsigned MAX_LABEL            = 63;
  localparam int unsigned RECORD_BYTES         = 16;
  localparam int unsigned TAIL_BYTES           = 5;

  localparam int unsigned FLAGS_POS  = 2;
  localparam int unsigned QDHI_POS   = 4;
  localparam int unsigned QDLO_POS   = 5;
  localparam logic [7:0]  QR_BIT     = 8'h80;
  localparam logic [7:0]  FLAGS_HI   = 8'h81;
  localparam logic [7:0]  FLAGS_LO   = 8'h80;
  localparam logic [7:0]  PTR_HI     = 8'hc0;
  localparam logic [7:0]  PTR_LO     = 8'h0c;

  localparam logic [31:0] SUBNET_RST = 32'hc0a8_0400;
  localparam logic [31:0] MASK_RST   = 32'hffff_ff00;
  localparam logic [31:0] ANSWER_RST = 32'hc0a8_0401;

  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_SUBNET = 2'd1;
  localparam logic [1:0] CFG_MASK   = 2'd2;
  localparam logic [1:0] CFG_ANSWER = 2'd3;

  typedef enum logic [2:0] {
    ST_REPLY      = 3'd0,
    ST_TOO_SHORT  = 3'd1,
    ST_DISABLED   = 3'd2,
    ST_NOT_QUERY  = 3'd3,
    ST_BAD_COUNT  = 3'd4,
    ST_FOREIGN    = 3'd5,
    ST_BAD_QUEST  = 3'd6
  } status_e;

  function automatic logic [7:0] header_byte(logic [3:0] idx, logic [7:0] orig);
    logic [7:0] res;
    res = orig;
    case (idx) inside
      4'd2:                      res = FLAGS_HI;
      4'd3:                      res = FLAGS_LO;
      4'd6, 4'd8, 4'd9, 4'd10, 4'd11: res = 8'h00;
      4'd7:                      res = 8'h01;
      default:                   res = orig;
    endcase
    return res;
  endfunction

  function automatic logic [7:0] record_byte(logic [3:0] k, logic [31:0] addr);
    logic [7:0] res;
    res = 8'h00;
    case (k) inside
      4'd0:       res = PTR_HI;
      4'd1:       res = PTR_LO;
      4'd3, 4'd5: res = 8'h01;
      4'd11:      res = 8'h04;
      4'd12:      res = addr[31:24];
      4'd13:      res = addr[23:16];
      4'd14:      res = addr[15:8];
      4'd15:      res = addr[7:0];
      default:    res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

@@ hdl/dns_a_query_responder.sv @@
// DNS A-query responder: packet store, header checks, name walk and reply framing.
//
// Input channel (in_valid_i/in_ready_o) carries one UDP payload byte per item,
// with last_byte_i on the final byte and source_address_i sampled with it.
// Bytes are taken at one per cycle while the block is idle; up to MAX_PACKET_BYTES are kept in a
// word-wide byte-write store, later bytes are dropped.
// After the last byte the block stops taking bytes and works on the packet:
// the header checks, then per name label and for the root byte a store read
// and an evaluate step, a store read and an evaluate step for each type and
// class byte, then per 8-byte reply word a store read and an output register load.
// A packet failing a header check gives one status item via the check and
// reject states; a bad question gives it via the reject state once the walk stops.
// A reply of n stored bytes gives ceil((n+16)/8) items, last_result_o on the last.
// The output register holds each item until out_ready_i; a stall simply
// holds the sequencer. Input is taken again once the final item is loaded,
// while that item still waits in the output register.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect at once
// and are expected only while the block is idle.
// Reset (rst_ni low) clears the configuration to its defaults, empties the
// byte count and drops any pending output; store contents are not cleared.
module dns_a_query_responder
  import dnsaqr_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = dnsaqr_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [31:0] source_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [63:0] reply_word_o,
  output logic [3:0]  byte_count_o,
  output logic        last_result_o
);

  localparam int unsigned CntW  = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned Words = (MAX_PACKET_BYTES + 7) / 8;
  localparam int unsigned WAW   = $clog2(Words);
  localparam int unsigned PosW  = $clog2(MAX_PACKET_BYTES + MAX_LABEL + 1);
  localparam int unsigned TotW  = $clog2(MAX_PACKET_BYTES + RECORD_BYTES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_WALK_RD, S_WALK_EV, S_TAIL_RD, S_TAIL_EV,
    S_SEND_RD, S_SEND_EV, S_REJECT
  } state_e;

  // configuration
  logic        enable_q;
  logic [31:0] subnet_q, mask_q, answer_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      subnet_q <= SUBNET_RST;
      mask_q   <= MASK_RST;
      answer_q <= ANSWER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ENABLE: enable_q <= cfg_data_i[0];
        CFG_SUBNET: subnet_q <= cfg_data_i;
        CFG_MASK:   mask_q   <= cfg_data_i;
        CFG_ANSWER: answer_q <= cfg_data_i;
        default:    enable_q <= enable_q;
      endcase
    end
  end

  // packet store
  logic [7:0]     store_mem [Words][8];
  logic [7:0]     rdata_q [8];
  logic           rd_en, wr_en;
  logic [WAW-1:0] rd_word, wr_word;
  logic [2:0]     wr_lane;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_word][wr_lane] <= data_byte_i;
    end
    if (rd_en) begin
      rdata_q <= store_mem[rd_word];
    end
  end

  // sequencer
  state_e          state_q, state_d;
  logic [CntW-1:0] byte_total_q, byte_total_d, n_q, n_d;
  logic [7:0]      b2_q, b2_d, b4_q, b4_d, b5_q, b5_d;
  logic [31:0]     src_q, src_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [1:0]      tail_q, tail_d;
  logic [TotW-1:0] base_q, base_d, rem_q, rem_d;
  status_e         code_q, code_d;

  logic            out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [2:0]      out_status_q, out_status_d;
  logic [63:0]     out_word_q, out_word_d;
  logic [3:0]      out_count_q, out_count_d;

  logic            in_fire, room, out_free;
  logic [7:0]      cur_byte;
  logic [PosW-1:0] n_pos, step;
  logic [TotW-1:0] n_tot, j;
  logic [63:0]     reply_word;
  logic [7:0]      lane_byte;
  logic [3:0]      send_count;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign room       = byte_total_q < CntW'(MAX_PACKET_BYTES);
  assign out_free   = !out_valid_q || out_ready_i;
  assign wr_en      = in_fire && room;
  assign wr_word    = WAW'(byte_total_q >> 3);
  assign wr_lane    = byte_total_q[2:0];
  assign cur_byte   = rdata_q[pos_q[2:0]];
  assign n_pos      = PosW'(n_q);
  assign n_tot      = TotW'(n_q);
  assign step       = pos_q + PosW'(1) + PosW'(cur_byte);
  assign send_count = (rem_q > TotW'(8)) ? 4'd8 : rem_q[3:0];

  always_comb begin
    reply_word = '0;
    for (int b = 0; b < 8; b++) begin
      j = base_q + TotW'(b);
      if (j < n_tot) begin
        lane_byte = (j < TotW'(HEADER_BYTES)) ? header_byte(j[3:0], rdata_q[b]) : rdata_q[b];
      end else if (j < n_tot + TotW'(RECORD_BYTES)) begin
        lane_byte = record_byte(4'(j - n_tot), answer_q);
      end else begin
        lane_byte = 8'h00;
      end
      reply_word[63 - 8*b -: 8] = lane_byte;
    end
  end

  always_comb begin
    state_d      = state_q;
    byte_total_d = byte_total_q;
    n_d          = n_q;
    b2_d         = b2_q;
    b4_d         = b4_q;
    b5_d         = b5_q;
    src_d        = src_q;
    pos_d        = pos_q;
    tail_d       = tail_q;
    base_d       = base_q;
    rem_d        = rem_q;
    code_d       = code_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_word_d   = out_word_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;
    rd_en        = 1'b0;
    rd_word      = WAW'(pos_q >> 3);

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (room) begin
            byte_total_d = byte_total_q + CntW'(1);
            if (byte_total_q == CntW'(FLAGS_POS)) b2_d = data_byte_i;
            if (byte_total_q == CntW'(QDHI_POS))  b4_d = data_byte_i;
            if (byte_total_q == CntW'(QDLO_POS))  b5_d = data_byte_i;
          end
          if (last_byte_i) begin
            n_d          = byte_total_q + CntW'(room);
            byte_total_d = '0;
            src_d        = source_address_i;
            state_d      = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        state_d = S_REJECT;
        if (n_q < CntW'(MIN_LENGTH)) begin
          code_d = ST_TOO_SHORT;
        end else if (!enable_q) begin
          code_d = ST_DISABLED;
        end else if ((b2_q & QR_BIT) != 8'h00) begin
          code_d = ST_NOT_QUERY;
        end else if (b4_q != 8'h00 || b5_q != 8'h01) begin
          code_d = ST_BAD_COUNT;
        end else if ((src_q & mask_q) != subnet_q) begin
          code_d = ST_FOREIGN;
        end else begin
          pos_d   = PosW'(HEADER_BYTES);
          state_d = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        if (pos_q >= n_pos) begin
          code_d  = ST_BAD_QUEST;
          state_d = S_REJECT;
        end else begin
          rd_en   = 1'b1;
          state_d = S_WALK_EV;
        end
      end
      S_WALK_EV: begin
        code_d  = ST_BAD_QUEST;
        state_d = S_REJECT;
        if (cur_byte == 8'h00) begin
          if (pos_q + PosW'(TAIL_BYTES) == n_pos) begin
            pos_d   = pos_q + PosW'(1);
            tail_d  = '0;
            state_d = S_TAIL_RD;
          end
        end else if (cur_byte <= 8'(MAX_LABEL) && step < n_pos) begin
          pos_d   = step;
          state_d = S_WALK_RD;
        end
      end
      S_TAIL_RD: begin
        rd_en   = 1'b1;
        state_d = S_TAIL_EV;
      end
      S_TAIL_EV: begin
        if (cur_byte != {7'd0, tail_q[0]}) begin
          code_d  = ST_BAD_QUEST;
          state_d = S_REJECT;
        end else if (tail_q == 2'd3) begin
          base_d  = '0;
          rem_d   = n_tot + TotW'(RECORD_BYTES);
          state_d = S_SEND_RD;
        end else begin
          tail_d  = tail_q + 2'd1;
          pos_d   = pos_q + PosW'(1);
          state_d = S_TAIL_RD;
        end
      end
      S_SEND_RD: begin
        rd_en   = (base_q < n_tot);
        rd_word = WAW'(base_q >> 3);
        state_d = S_SEND_EV;
      end
      S_SEND_EV: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_REPLY;
          out_word_d   = reply_word;
          out_count_d  = send_count;
          out_last_d   = (rem_q <= TotW'(8));
          base_d       = base_q + TotW'(8);
          rem_d        = rem_q - TotW'(8);
          state_d      = (rem_q <= TotW'(8)) ? S_IDLE : S_SEND_RD;
        end
      end
      S_REJECT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = code_q;
          out_word_d   = '0;
          out_count_d  = '0;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      byte_total_q <= '0;
      n_q          <= '0;
      b2_q         <= '0;
      b4_q         <= '0;
      b5_q         <= '0;
      src_q        <= '0;
      pos_q        <= PosW'(HEADER_BYTES);
      tail_q       <= '0;
      base_q       <= '0;
      rem_q        <= '0;
      code_q       <= ST_REPLY;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_word_q   <= '0;
      out_count_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      byte_total_q <= byte_total_d;
      n_q          <= n_d;
      b2_q         <= b2_d;
      b4_q         <= b4_d;
      b5_q         <= b5_d;
      src_q        <= src_d;
      pos_q        <= pos_d;
      tail_q       <= tail_d;
      base_q       <= base_d;
      rem_q        <= rem_d;
      code_q       <= code_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_word_q   <= out_word_d;
      out_count_q  <= out_count_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign reply_word_o  = out_word_q;
  assign byte_count_o  = out_count_q;
  assign last_result_o = out_last_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_total_q <= CntW'(MAX_PACKET_BYTES))
    else $error("byte count beyond store depth");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_byte_i |=> byte_total_q == '0 && !in_ready_o)
    else $error("byte count not cleared at end of packet");

  a_reject_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_REPLY |-> byte_count_o == 4'd0 && last_result_o)
    else $error("rejection item malformed");

  a_reply_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_REPLY |-> byte_count_o != 4'd0 && byte_count_o <= 4'd8)
    else $error("reply byte count out of range");

  a_tail_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TAIL_RD |-> pos_q < n_pos)
    else $error("tail read beyond packet");

endmodule
